@@ rtl/adcvt_pkg.sv @@
// shared types, constants and the digit weight function for the converter text block
// no dependencies; every other file in this folder imports it

package adcvt_pkg;

   // screen geometry
   localparam int SCREEN_ROWS        = 64;
   localparam int SCREEN_COLUMNS     = 128;
   localparam int SMALL_GLYPH_HEIGHT = 8;
   localparam int SMALL_GLYPH_WIDTH  = 6;
   localparam int TEXT_LEN           = 9;

   // job queue depth between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // scaling
   localparam int PROD_W = 46;
   localparam int MAG_W  = 22;
   localparam int STEP_W = 24;
   localparam logic [MAG_W-1:0]   HALF_SCALE = 22'd2500000;
   localparam logic [MAG_W:0]     HALF_SCALE_EXT = 23'd2500000;

   // presentation mode codes
   localparam logic [7:0] MODE_BIPOLAR_BIG    = 8'd32;
   localparam logic [7:0] MODE_UNIPOLAR_SML_A = 8'd33;
   localparam logic [7:0] MODE_UNIPOLAR_SML_B = 8'd34;
   localparam logic [7:0] MODE_UNIPOLAR_BIG   = 8'd35;
   localparam logic [7:0] MODE_UNIPOLAR_SML_C = 8'd36;

   // placement
   localparam logic [7:0]  LEFT_COL   = 8'd8;
   localparam logic [7:0]  CORNER_COL = 8'd2;
   localparam logic [7:0]  RIGHT_COL  =
      8'(SCREEN_COLUMNS - TEXT_LEN * SMALL_GLYPH_WIDTH);
   localparam logic [12:0] TOP_ROW    = 13'd20;
   localparam logic [12:0] ROW_PITCH  = 13'd11;
   localparam logic [12:0] BOTTOM_ROW = 13'(SCREEN_ROWS - SMALL_GLYPH_HEIGHT);
   localparam logic [7:0]  CHAN_CORNER = 8'd2;

   // character positions within the text
   localparam logic [3:0] POS_SIGN  = 4'd0;
   localparam logic [3:0] POS_INT   = 4'd1;
   localparam logic [3:0] POS_POINT = 4'd2;
   localparam logic [3:0] POS_LAST  = 4'd8;

   // ascii codes
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_POINT = 7'h2E;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_NINE  = 7'h39;

   // one formatted job handed from front to back
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic [7:0]       text_x;
      logic [12:0]      text_y;
      logic             big_font;
   } text_job_type;

   // weight of a digit value at a text position; zero where no digit stands
   function automatic logic [STEP_W-1:0] digit_step(input logic [3:0] pos,
                                                    input logic [3:0] digit);
      logic [STEP_W-1:0] weight;
      unique case (pos)
         POS_INT: weight = 24'd1000000;
         4'd3:    weight = 24'd100000;
         4'd4:    weight = 24'd10000;
         4'd5:    weight = 24'd1000;
         4'd6:    weight = 24'd100;
         4'd7:    weight = 24'd10;
         POS_LAST: weight = 24'd1;
         default: weight = '0;
      endcase
      return weight * STEP_W'(digit);
   endfunction

endpackage

@@ rtl/adcvt_front.sv @@
// front end: takes a reading word, scales it to microvolts and works out placement
// depends on adcvt_pkg; feeds adcvt_queue

module adcvt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_mode,
   input  logic [23:0]               req_adc_code,
   input  logic [7:0]                req_channel,
   output logic                      push,
   output adcvt_pkg::text_job_type   push_job,
   input  logic                      q_full
);
   import adcvt_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                uni_ff, uni_in;
   logic                big_ff, big_in;
   logic [7:0]          x_ff, x_in;
   logic [12:0]         y_ff, y_in;
   logic                big_raw;
   logic [12:0]         row_off;
   logic                accept;
   logic [MAG_W:0]      volts;
   logic                neg;
   logic [MAG_W-1:0]    mag;

   assign req_tready = !s1_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = s1_valid_ff && !q_full;

   // classify the mode and place the text
   always_comb begin
      big_raw = (req_mode == MODE_BIPOLAR_BIG) || (req_mode == MODE_UNIPOLAR_BIG);
      uni_in  = (req_mode == MODE_UNIPOLAR_BIG) || (req_mode == MODE_UNIPOLAR_SML_A) ||
                (req_mode == MODE_UNIPOLAR_SML_B) || (req_mode == MODE_UNIPOLAR_SML_C);
      prod_in = PROD_W'(req_adc_code) * PROD_W'(HALF_SCALE);
      row_off = 13'(req_channel) * ROW_PITCH;
      if (big_raw && (req_channel > 8'd1)) begin
         big_in = 1'b0;
         y_in   = BOTTOM_ROW;
         x_in   = (req_channel == CHAN_CORNER) ? CORNER_COL : RIGHT_COL;
      end else begin
         big_in = big_raw;
         y_in   = TOP_ROW + (big_raw ? {row_off[11:0], 1'b0} : row_off);
         x_in   = LEFT_COL;
      end
   end

   // stage valid
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // product and placement register
   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= prod_in;
         uni_ff  <= uni_in;
         big_ff  <= big_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
      end
   end

   // magnitude and sign from the registered product
   always_comb begin
      volts = prod_ff[PROD_W-1:PROD_W-MAG_W-1];
      if (uni_ff) begin
         neg = 1'b0;
         mag = prod_ff[PROD_W-1:PROD_W-MAG_W];
      end else if (volts < HALF_SCALE_EXT) begin
         neg = 1'b1;
         mag = MAG_W'(HALF_SCALE_EXT - volts);
      end else begin
         neg = 1'b0;
         mag = MAG_W'(volts - HALF_SCALE_EXT);
      end
      push_job.mag      = mag;
      push_job.neg      = neg;
      push_job.text_x   = x_ff;
      push_job.text_y   = y_ff;
      push_job.big_font = big_ff;
   end

endmodule

@@ rtl/adcvt_queue.sv @@
// short job queue between the front end and the character back end
// depends on adcvt_pkg for the job type

module adcvt_queue #(
   parameter int DEPTH = adcvt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  adcvt_pkg::text_job_type   push_job,
   output logic                      full,
   input  logic                      pop,
   output adcvt_pkg::text_job_type   pop_job,
   output logic                      empty
);
   import adcvt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   text_job_type        jobs_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = jobs_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         jobs_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");
   assert property (@(posedge clock) disable iff (reset) full |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with full count");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
`endif

endmodule

@@ rtl/adcvt_back.sv @@
// back end: a queued job becomes nine characters, one per unstalled cycle
// depends on adcvt_pkg; drains adcvt_queue and drives the result register

module adcvt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  adcvt_pkg::text_job_type   q_job,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [6:0]                rsp_char_code,
   output logic [3:0]                rsp_char_index,
   output logic [7:0]                rsp_text_x,
   output logic [12:0]               rsp_text_y,
   output logic                      rsp_big_font,
   output logic                      rsp_last
);
   import adcvt_pkg::*;

   logic                active_ff, active_in;
   logic [3:0]          pos_ff, pos_in;
   logic [MAG_W-1:0]    rem_ff, rem_in;
   logic                neg_ff;
   logic [7:0]          x_ff;
   logic [12:0]         y_ff;
   logic                big_ff;

   logic                rsp_valid_ff;
   logic [6:0]          char_ff, char_in;
   logic [3:0]          index_ff;
   logic [7:0]          out_x_ff;
   logic [12:0]         out_y_ff;
   logic                out_big_ff;
   logic                last_ff;

   logic                out_adv;
   logic                emit;
   logic                finishing;
   logic [3:0]          digit;
   logic [STEP_W-1:0]   sel_step;

   assign out_adv   = !rsp_valid_ff || rsp_tready;
   assign emit      = active_ff && out_adv;
   assign finishing = emit && (pos_ff == POS_LAST);
   assign q_pop     = q_valid && (!active_ff || finishing);

   // largest digit whose weight still fits the remainder
   always_comb begin
      digit    = '0;
      sel_step = '0;
      for (int d = 1; d <= 9; d++) begin
         if (STEP_W'(rem_ff) >= digit_step(pos_ff, 4'(d))) begin
            digit    = 4'(d);
            sel_step = digit_step(pos_ff, 4'(d));
         end
      end
   end

   // character at the current position
   always_comb begin
      unique case (pos_ff)
         POS_SIGN:  char_in = neg_ff ? CHAR_MINUS : CHAR_SPACE;
         POS_POINT: char_in = CHAR_POINT;
         default:   char_in = CHAR_ZERO + 7'(digit);
      endcase
   end

   // job sequencing
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      if (q_pop) begin
         active_in = 1'b1;
         pos_in    = POS_SIGN;
         rem_in    = q_job.mag;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (emit) begin
         pos_in = pos_ff + 1'b1;
         rem_in = MAG_W'(STEP_W'(rem_ff) - sel_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= POS_SIGN;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (q_pop) begin
         neg_ff <= q_job.neg;
         x_ff   <= q_job.text_x;
         y_ff   <= q_job.text_y;
         big_ff <= q_job.big_font;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff    <= char_in;
         index_ff   <= pos_ff;
         out_x_ff   <= x_ff;
         out_y_ff   <= y_ff;
         out_big_ff <= big_ff;
         last_ff    <= (pos_ff == POS_LAST);
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_char_code  = char_ff;
   assign rsp_char_index = index_ff;
   assign rsp_text_x     = out_x_ff;
   assign rsp_text_y     = out_y_ff;
   assign rsp_big_font   = out_big_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> last_ff == (index_ff == POS_LAST))
      else $error("last flag out of step with character index");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> active_ff && pos_ff == POS_SIGN)
      else $error("job load did not restart the text");
   assert property (@(posedge clock) disable iff (reset)
      active_ff && pos_ff > POS_INT |-> rem_ff < 22'd1000000)
      else $error("fraction remainder out of range");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && index_ff != POS_SIGN && index_ff != POS_POINT |->
      char_ff >= CHAR_ZERO && char_ff <= CHAR_NINE)
      else $error("digit position carries a non-digit");
`endif

endmodule

@@ rtl/adc_code_to_voltage_text_top.sv @@
// Converter code to voltage text.
// The req channel takes one reading word: mode, 24-bit code and channel.
// Each reading is scaled to microvolts (unipolar or bipolar by mode) and
// leaves on the rsp channel as nine character words in text order: sign,
// integer digit, point and six fraction digits, each with its position,
// the text column and row and the font flag; tlast marks the ninth word.
// Each reading passes the front stage register, the job queue, the back end
// position register and the result register before its first character shows.
// The back end sets the pace: it produces one character a cycle while
// rsp_tready lets the result register advance, from a single digit compare unit.
// A reading may be taken while the previous one is still being written out;
// a small job queue (QUEUE_DEPTH entries) plus the front stage absorb them.
// When the receiver holds tready low the current word holds, the back end
// stops, and req_tready falls once the queue and front stage are full.
// Reset (synchronous, active high) drops every reading in flight and leaves
// both channels idle.
// Depends on adcvt_pkg, adcvt_front, adcvt_queue and adcvt_back.

module adc_code_to_voltage_text_top #(
   parameter int QUEUE_DEPTH = adcvt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // mode[7:0], adc_code[31:8], channel[39:32]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // char_code[6:0], char_index[10:7],
                                      // text_x[18:11], text_y[31:19]
   output logic          rsp_tuser,   // big_font[0]
   output logic          rsp_tlast
);
   import adcvt_pkg::*;

   logic            push;
   text_job_type    push_job;
   logic            q_full;
   logic            q_pop;
   text_job_type    pop_job;
   logic            q_empty;
   logic [6:0]      char_code;
   logic [3:0]      char_index;
   logic [7:0]      text_x;
   logic [12:0]     text_y;

   // reading intake and scaling
   adcvt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_mode     (req_tdata[7:0]),
      .req_adc_code (req_tdata[31:8]),
      .req_channel  (req_tdata[39:32]),
      .push         (push),
      .push_job     (push_job),
      .q_full       (q_full)
   );

   // job queue
   adcvt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // character generation
   adcvt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (!q_empty),
      .q_job          (pop_job),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_char_code  (char_code),
      .rsp_char_index (char_index),
      .rsp_text_x     (text_x),
      .rsp_text_y     (text_y),
      .rsp_big_font   (rsp_tuser),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {text_y, text_x, char_index, char_code};

endmodule
